// File: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/ctr_pkg.sv
`timescale 1ns / 1ps

package ctr_pkg;

  // Field widths
  localparam int TempBits  = 16;
  localparam int CodeBits  = 8;
  localparam int CodeCount = 1 << CodeBits;

  // log2 format: integer part of a 16-bit operand plus Q24 fraction
  localparam int FracBits   = 24;
  localparam int TopBits    = 4;
  localparam int MantBits   = 31;
  localparam int LogBits    = TopBits + FracBits;
  localparam int LogLatency = FracBits + 1;

  // Branch points on the kelvin value
  localparam logic [TempBits-1:0] KSplit    = TempBits'(6600);
  localparam logic [TempBits-1:0] KBlueZero = TempBits'(1900);
  localparam logic [TempBits-1:0] KPowBase  = TempBits'(6000);
  localparam logic [TempBits-1:0] KBlueBase = TempBits'(1000);

  // Decimal constants are integers scaled by 10^8
  localparam logic [63:0] DecScale = 64'd100000000;

  // Natural log from log2: ln = log2 * ln(2) in Q30, then drop 30 bits
  localparam int Ln2Bits    = 30;
  localparam int LnProdBits = LogBits + Ln2Bits;
  localparam logic [Ln2Bits-1:0] Ln2Q30 = Ln2Bits'(744261118);

  // Power-law exponents, scaled by 10^8
  localparam int ExpoBits    = 24;
  localparam int PowProdBits = ExpoBits + LogBits;
  localparam logic [ExpoBits-1:0] ExpoRed   = ExpoBits'(13320476);
  localparam logic [ExpoBits-1:0] ExpoGreen = ExpoBits'(7551485);

  // Log-channel gains, split in two halves for the partial products
  localparam int GainBits   = 34;
  localparam int GainLoBits = 17;
  localparam int GainHiBits = GainBits - GainLoBits;
  localparam logic [GainBits-1:0] GainGlow = 34'd9947080259;
  localparam logic [GainBits-1:0] GainBlue = 34'd13851773122;
  localparam logic [GainLoBits-1:0] GainGlowLo = GainLoBits'(GainGlow);
  localparam logic [GainHiBits-1:0] GainGlowHi = GainHiBits'(GainGlow >> GainLoBits);
  localparam logic [GainLoBits-1:0] GainBlueLo = GainLoBits'(GainBlue);
  localparam logic [GainHiBits-1:0] GainBlueHi = GainHiBits'(GainBlue >> GainLoBits);

  // Log-channel thresholds: code c holds when gain*ln >= 10^8*(offset_q24 + c*2^24)
  localparam int LogThrBits = LogBits + GainBits;
  localparam logic [63:0] GlowOffsetQ = (64'd16111956817 << FracBits) / DecScale;
  localparam logic [63:0] BlueOffsetQ = (64'd30504479273 << FracBits) / DecScale;
  localparam logic [LogThrBits-1:0] GlowBase = LogThrBits'(DecScale * GlowOffsetQ);
  localparam logic [LogThrBits-1:0] BlueBase = LogThrBits'(DecScale * BlueOffsetQ);
  localparam logic [LogThrBits-1:0] KStep    = LogThrBits'(DecScale << FracBits);

  localparam logic [CodeBits-1:0] CodeMax = '1;

  // log2 in Q24 of a constant, by repeated squaring of the mantissa
  function automatic logic [63:0] log2_q24_const(input logic [63:0] n);
    int          top;
    logic [63:0] mant;
    logic [63:0] frac;
    top  = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) begin
      if (n[i]) top = i;
    end
    if (top <= MantBits - 1) mant = n << (MantBits - 1 - top);
    else mant = n >> (top - (MantBits - 1));
    for (int i = 0; i < FracBits; i++) begin
      mant = (mant * mant) >> (MantBits - 1);
      frac = frac << 1;
      if (mant >= (64'd1 << MantBits)) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(top) << FracBits) + frac;
  endfunction

  localparam logic [LogBits-1:0] Log2Hundred = LogBits'(log2_q24_const(64'd100));

  // Power-channel thresholds: code c holds when expo*l < 10^8*(log2 scale - log2 c + 1)
  localparam int PowThrBits = 56;
  typedef logic [CodeCount-1:0][PowThrBits-1:0] pow_thr_t;

  function automatic pow_thr_t build_pow_thr(input logic [63:0] gain);
    pow_thr_t tab;
    longint   scale_log;
    longint   diff;
    tab       = '0;
    scale_log = longint'(log2_q24_const(gain)) - longint'(log2_q24_const(DecScale));
    for (int c = 1; c < CodeCount; c++) begin
      diff = scale_log - longint'(log2_q24_const(64'(c))) + 64'sd1;
      if (diff > 0) tab[c] = PowThrBits'(diff * longint'(DecScale));
    end
    return tab;
  endfunction

  localparam pow_thr_t RedThr   = build_pow_thr(64'd32969873745);
  localparam pow_thr_t GreenThr = build_pow_thr(64'd28812216953);

endpackage

// File: rtl/ctr_log2_pipe.sv
`timescale 1ns / 1ps

module ctr_log2_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ctr_pkg::TempBits-1:0] n_i,
  output logic                         valid_o,
  output logic [ctr_pkg::LogBits-1:0]  log2_o
);
  import ctr_pkg::*;

  typedef struct packed {
    logic [MantBits-1:0] mant;
    logic [FracBits-1:0] frac;
    logic [TopBits-1:0]  top;
  } lg_stage_t;

  lg_stage_t                stage_d [FracBits+1];
  lg_stage_t                stage_q [FracBits+1];
  logic [FracBits:0]        valid_q;
  logic [TopBits-1:0]       top;
  logic [2*MantBits-1:0]    square [FracBits];
  logic [MantBits:0]        square_hi [FracBits];

  always_comb begin
    // Find the leading one and normalize the mantissa into [1,2) in Q30
    top = '0;
    for (int i = 0; i < TempBits; i++) begin
      if (n_i[i]) top = TopBits'(i);
    end
    stage_d[0].top  = top;
    stage_d[0].frac = '0;
    stage_d[0].mant = MantBits'(n_i) << ((MantBits - 1) - int'(top));

    // Square the mantissa once per stage; an overflow past 2 yields a one bit
    for (int s = 0; s < FracBits; s++) begin
      square[s]         = stage_q[s].mant * stage_q[s].mant;
      square_hi[s]      = square[s][2*MantBits-1:MantBits-1];
      stage_d[s+1].top  = stage_q[s].top;
      if (square_hi[s][MantBits]) begin
        stage_d[s+1].mant = square_hi[s][MantBits:1];
        stage_d[s+1].frac = {stage_q[s].frac[FracBits-2:0], 1'b1};
      end else begin
        stage_d[s+1].mant = square_hi[s][MantBits-1:0];
        stage_d[s+1].frac = {stage_q[s].frac[FracBits-2:0], 1'b0};
      end
    end
  end

  // Advance the data stages
  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= FracBits; s++) begin
      stage_q[s] <= stage_d[s];
    end
  end

  // Advance the valid bits alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[FracBits-1:0], valid_i};
    end
  end

  assign valid_o = valid_q[FracBits];
  assign log2_o  = {stage_q[FracBits].top, stage_q[FracBits].frac};

endmodule

// File: rtl/color_temperature_to_rgb_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Color temperature to RGB converter, piecewise blackbody curve fit.
//
// Request channel: drive temperature_kelvin_i and raise start; the request
// is taken at each rising edge where start is high and busy is low. busy
// stays low, so a new request may be taken in every cycle.
// Result channel: done_o is high for one cycle with red_code_o, green_code_o
// and blue_code_o; results leave in request order, one per request.
// Pipeline: a request passes through an input register, two 25-stage log2
// units (a normalize stage, then one mantissa squaring per stage), four
// stages of offset and multiply, an 8-stage code search and an output
// register.
// Throughput: one request per cycle, sustained.
// Reset clears every valid bit; requests still in flight are dropped and
// no result appears for them. The receiver takes every result in the
// cycle it is shown and cannot stall the block.
module color_temperature_to_rgb_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ctr_pkg::TempBits-1:0] temperature_kelvin_i,
  output logic                         done_o,
  output logic [ctr_pkg::CodeBits-1:0] red_code_o,
  output logic [ctr_pkg::CodeBits-1:0] green_code_o,
  output logic [ctr_pkg::CodeBits-1:0] blue_code_o
);
  import ctr_pkg::*;

  localparam int FlagDepth = LogLatency + 4 + CodeBits;
  localparam int Latency   = FlagDepth + 2;

  typedef struct packed {
    logic low;
    logic blue_full;
    logic blue_zero;
  } chan_sel_t;

  typedef struct packed {
    logic [LogThrBits-1:0] p;
    logic [LogThrBits-1:0] thr;
    logic [CodeBits-1:0]   code;
  } log_srch_t;

  typedef struct packed {
    logic [PowProdBits-1:0] prod;
    logic [CodeBits-1:0]    code;
  } pow_srch_t;

  // One bit of the log-channel search: keep the bit if the product reaches the next step
  function automatic log_srch_t log_step(input log_srch_t cur,
                                         input logic [LogThrBits-1:0] step,
                                         input logic [CodeBits-1:0] mask);
    log_srch_t             nxt;
    logic [LogThrBits-1:0] trial;
    nxt   = cur;
    trial = cur.thr + step;
    if (cur.p >= trial) begin
      nxt.thr  = trial;
      nxt.code = cur.code | mask;
    end
    return nxt;
  endfunction

  // One bit of the power-channel search against the per-code threshold table
  function automatic pow_srch_t pow_step(input pow_srch_t cur,
                                         input pow_thr_t tab,
                                         input logic [CodeBits-1:0] mask);
    pow_srch_t           nxt;
    logic [CodeBits-1:0] cand;
    nxt  = cur;
    cand = cur.code | mask;
    if (PowThrBits'(cur.prod) < tab[cand]) nxt.code = cand;
    return nxt;
  endfunction

  logic                   accept;
  logic                   k_valid_q;
  logic [TempBits-1:0]    k_q;
  chan_sel_t              sel_d;
  chan_sel_t              sel_q [FlagDepth];
  logic [TempBits-1:0]    n_a;
  logic [TempBits-1:0]    n_b;
  logic                   log_valid;
  logic [LogBits-1:0]     log_a;
  logic [LogBits-1:0]     log_b;

  logic                   d_valid_q;
  logic [LogBits-1:0]     l_a_d, l_a_q;
  logic [LogBits-1:0]     l_b_d, l_b_q;

  logic                   m1_valid_q;
  logic [PowProdBits-1:0] prod_red_q, prod_green_q;
  logic [LnProdBits-1:0]  ln_prod_a_q, ln_prod_b_q;

  logic                   m2_valid_q;
  logic [PowProdBits-1:0] prod_red_m2_q, prod_green_m2_q;
  logic [LogBits-1:0]     lnq_a, lnq_b;
  logic [LogBits+GainLoBits-1:0] pp_glow_lo_q, pp_blue_lo_q;
  logic [LogBits+GainHiBits-1:0] pp_glow_hi_q, pp_blue_hi_q;

  logic [CodeBits:0]      srch_valid_q;
  log_srch_t              glow_d [CodeBits+1];
  log_srch_t              glow_q [CodeBits+1];
  log_srch_t              blue_log_d [CodeBits+1];
  log_srch_t              blue_log_q [CodeBits+1];
  pow_srch_t              rpow_d [CodeBits+1];
  pow_srch_t              rpow_q [CodeBits+1];
  pow_srch_t              gpow_d [CodeBits+1];
  pow_srch_t              gpow_q [CodeBits+1];

  chan_sel_t              sel_out;
  logic                   done_q;
  logic [CodeBits-1:0]    red_q, green_q, blue_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_valid_q <= 1'b0;
    end else begin
      k_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) k_q <= temperature_kelvin_i;
  end

  // Decode the branches and pick the log2 operands
  always_comb begin
    sel_d.low       = (k_q <= KSplit);
    sel_d.blue_full = (k_q >= KSplit);
    sel_d.blue_zero = (k_q <= KBlueZero);
    n_a = sel_d.low ? k_q : k_q - KPowBase;
    n_b = k_q - KBlueBase;
  end

  // Delay the branch flags to the output stage
  always_ff @(posedge clk_i) begin
    sel_q[0] <= sel_d;
    for (int i = 1; i < FlagDepth; i++) begin
      sel_q[i] <= sel_q[i-1];
    end
  end

  ctr_log2_pipe u_log_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (k_valid_q),
    .n_i     (n_a),
    .valid_o (log_valid),
    .log2_o  (log_a)
  );

  ctr_log2_pipe u_log_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (k_valid_q),
    .n_i     (n_b),
    .valid_o (),
    .log2_o  (log_b)
  );

  // Scale down by 100; a non-positive log gives a zero log-channel code
  always_comb begin
    l_a_d = (log_a > Log2Hundred) ? log_a - Log2Hundred : '0;
    l_b_d = (log_b > Log2Hundred) ? log_b - Log2Hundred : '0;
  end

  // Valid bits for the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q    <= 1'b0;
      m1_valid_q   <= 1'b0;
      m2_valid_q   <= 1'b0;
      srch_valid_q <= '0;
    end else begin
      d_valid_q    <= log_valid;
      m1_valid_q   <= d_valid_q;
      m2_valid_q   <= m1_valid_q;
      srch_valid_q <= {srch_valid_q[CodeBits-1:0], m2_valid_q};
    end
  end

  // Drop the Q30 fraction of the natural log
  assign lnq_a = ln_prod_a_q[LnProdBits-1:Ln2Bits];
  assign lnq_b = ln_prod_b_q[LnProdBits-1:Ln2Bits];

  // Offset, exponent and ln(2) products, then the gain partial products
  always_ff @(posedge clk_i) begin
    l_a_q           <= l_a_d;
    l_b_q           <= l_b_d;
    prod_red_q      <= ExpoRed * l_a_q;
    prod_green_q    <= ExpoGreen * l_a_q;
    ln_prod_a_q     <= l_a_q * Ln2Q30;
    ln_prod_b_q     <= l_b_q * Ln2Q30;
    prod_red_m2_q   <= prod_red_q;
    prod_green_m2_q <= prod_green_q;
    pp_glow_lo_q    <= lnq_a * GainGlowLo;
    pp_glow_hi_q    <= lnq_a * GainGlowHi;
    pp_blue_lo_q    <= lnq_b * GainBlueLo;
    pp_blue_hi_q    <= lnq_b * GainBlueHi;
  end

  // Seed the searches, then settle one code bit per stage from the top
  always_comb begin
    glow_d[0].p    = LogThrBits'(pp_glow_lo_q) + (LogThrBits'(pp_glow_hi_q) << GainLoBits);
    glow_d[0].thr  = GlowBase;
    glow_d[0].code = '0;
    blue_log_d[0].p    = LogThrBits'(pp_blue_lo_q) + (LogThrBits'(pp_blue_hi_q) << GainLoBits);
    blue_log_d[0].thr  = BlueBase;
    blue_log_d[0].code = '0;
    rpow_d[0].prod = prod_red_m2_q;
    rpow_d[0].code = '0;
    gpow_d[0].prod = prod_green_m2_q;
    gpow_d[0].code = '0;
    for (int s = 0; s < CodeBits; s++) begin
      glow_d[s+1] = log_step(glow_q[s], KStep << (CodeBits - 1 - s),
                             CodeBits'(1) << (CodeBits - 1 - s));
      blue_log_d[s+1] = log_step(blue_log_q[s], KStep << (CodeBits - 1 - s),
                                 CodeBits'(1) << (CodeBits - 1 - s));
      rpow_d[s+1] = pow_step(rpow_q[s], RedThr, CodeBits'(1) << (CodeBits - 1 - s));
      gpow_d[s+1] = pow_step(gpow_q[s], GreenThr, CodeBits'(1) << (CodeBits - 1 - s));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= CodeBits; s++) begin
      glow_q[s]     <= glow_d[s];
      blue_log_q[s] <= blue_log_d[s];
      rpow_q[s]     <= rpow_d[s];
      gpow_q[s]     <= gpow_d[s];
    end
  end

  // Select each channel by branch and register the result; the codes hold until the next result
  assign sel_out = sel_q[FlagDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= srch_valid_q[CodeBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (srch_valid_q[CodeBits]) begin
      red_q   <= sel_out.low ? CodeMax : rpow_q[CodeBits].code;
      green_q <= sel_out.low ? glow_q[CodeBits].code : gpow_q[CodeBits].code;
      if (sel_out.blue_full) blue_q <= CodeMax;
      else if (sel_out.blue_zero) blue_q <= '0;
      else blue_q <= blue_log_q[CodeBits].code;
    end
  end

  assign done_o       = done_q;
  assign red_code_o   = red_q;
  assign green_code_o = green_q;
  assign blue_code_o  = blue_q;

  // Every request yields a result after the full pipeline depth, and no other
  `ASSERT_CLK(a_result_follows, clk_i, rst_ni, accept |-> ##Latency done_o, "result missing")
  `ASSERT_CLK(a_result_has_request, clk_i, rst_ni, done_o |-> $past(accept, Latency), "extra result")
  // Red is full below the split and blue is full above it
  `ASSERT_NEVER(a_split_full, clk_i, rst_ni, done_o && (red_code_o != CodeMax) && (blue_code_o != CodeMax), "no full channel")

endmodule

// File: bench/color_temperature_to_rgb_top_tb.sv
`timescale 1ns / 1ps

module color_temperature_to_rgb_top_tb;

  localparam int KelvinBits = ctr_pkg::TempBits;
  localparam int ChanBits   = ctr_pkg::CodeBits;

  // Curve-fit constants, scaled by 10^8 (ln(2) in Q30)
  localparam longint ScaleDec       = 64'sd100000000;
  localparam longint LnTwoQ30       = 64'sd744261118;
  localparam longint RedGain        = 64'sd32969873745;
  localparam longint RedExpo        = 64'sd13320476;
  localparam longint GreenLowGain   = 64'sd9947080259;
  localparam longint GreenLowOffset = 64'sd16111956817;
  localparam longint GreenHighGain  = 64'sd28812216953;
  localparam longint GreenHighExpo  = 64'sd7551485;
  localparam longint BlueGain       = 64'sd13851773122;
  localparam longint BlueOffset     = 64'sd30504479273;

  // Branch points in kelvin
  localparam longint KelvinSplit    = 6600;
  localparam longint KelvinBlueOff  = 1900;
  localparam longint KelvinPowBase  = 6000;
  localparam longint KelvinBlueBase = 1000;

  localparam logic [ChanBits-1:0] ChanFull = '1;
  localparam int DrainCycles = 50;
  localparam int TailItems   = 200;
  localparam int RandomItems = 1025;

  typedef struct {
    logic [KelvinBits-1:0] kelvin;
    logic [ChanBits-1:0]   red;
    logic [ChanBits-1:0]   green;
    logic [ChanBits-1:0]   blue;
  } rgb_t;

  typedef struct {
    logic [KelvinBits-1:0] kelvin;
    bit                    settle_first;
  } kelvin_req_t;

  localparam logic [KelvinBits-1:0] CornerKelvin [0:24] = '{
    16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd1000, 16'd1899, 16'd1900,
    16'd1901, 16'd2000, 16'd4000, 16'd6000, 16'd6599, 16'd6600, 16'd6601,
    16'd6602, 16'd6700, 16'd10000, 16'd32768, 16'd40000, 16'd65534,
    16'd65535, 16'h5555, 16'hAAAA, 16'd255
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KelvinBits-1:0] temperature_kelvin_i = '0;
  logic                  done_o;
  logic [ChanBits-1:0]   red_code_o;
  logic [ChanBits-1:0]   green_code_o;
  logic [ChanBits-1:0]   blue_code_o;

  kelvin_req_t kelvin_queue[$];
  rgb_t        rgb_queue[$];
  int          rgb_in_flight = 0;
  int          gap_left = 0;
  int          failures = 0;
  int          results_checked = 0;
  int          requests_taken = 0;
  int          hot_requests = 0;
  int          cool_requests = 0;

  color_temperature_to_rgb_top u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .temperature_kelvin_i(temperature_kelvin_i),
    .done_o              (done_o),
    .red_code_o          (red_code_o),
    .green_code_o        (green_code_o),
    .blue_code_o         (blue_code_o)
  );

  always #2 clk_i = ~clk_i;

  // log2 of a positive integer in Q24 by repeated mantissa squaring
  function automatic longint log2_fixed(input longint unsigned n);
    int              top;
    longint unsigned mant;
    longint unsigned frac;
    top  = 0;
    frac = 0;
    if (n == 0) return 0;
    for (int i = 0; i < 64; i++) begin
      if (n[i]) top = i;
    end
    if (top <= 30) mant = n << (30 - top);
    else mant = n >> (top - 30);
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(top) << 24) + longint'(frac);
  endfunction

  // gain * ln(n/100) - offset, saturated and floored
  function automatic logic [ChanBits-1:0] log_code(input longint n, input longint gain,
                                                   input longint offset);
    longint l;
    longint lnq;
    longint off;
    longint v;
    l   = log2_fixed(n) - log2_fixed(100);
    lnq = (l * LnTwoQ30) / (64'sd1 <<< 30);
    off = (offset * (64'sd1 <<< 24)) / ScaleDec;
    v   = (gain * lnq) / ScaleDec - off;
    if (v <= 0) return '0;
    if ((v >>> 24) >= 255) return ChanFull;
    return v[31:24];
  endfunction

  // gain * (excess/100)^-expo, largest code whose log2 stays at or below it
  function automatic logic [ChanBits-1:0] power_code(input longint excess, input longint gain,
                                                     input longint expo);
    longint              l;
    longint              r;
    logic [ChanBits-1:0] code;
    logic [ChanBits-1:0] trial;
    l    = log2_fixed(excess) - log2_fixed(100);
    r    = log2_fixed(gain) - log2_fixed(ScaleDec) - (expo * l) / ScaleDec;
    code = '0;
    for (int b = ChanBits - 1; b >= 0; b--) begin
      trial = code | (ChanBits'(1) << b);
      if (log2_fixed(longint'(trial)) <= r) code = trial;
    end
    return code;
  endfunction

  function automatic rgb_t blackbody_rgb(input logic [KelvinBits-1:0] kelvin);
    rgb_t   px;
    longint k;
    k         = longint'(kelvin);
    px.kelvin = kelvin;
    if (k <= KelvinSplit) begin
      px.red   = ChanFull;
      px.green = (k == 0) ? '0 : log_code(k, GreenLowGain, GreenLowOffset);
    end else begin
      px.red   = power_code(k - KelvinPowBase, RedGain, RedExpo);
      px.green = power_code(k - KelvinPowBase, GreenHighGain, GreenHighExpo);
    end
    if (k >= KelvinSplit) px.blue = ChanFull;
    else if (k <= KelvinBlueOff) px.blue = '0;
    else px.blue = log_code(k - KelvinBlueBase, BlueGain, BlueOffset);
    return px;
  endfunction

  task automatic add_kelvin(input logic [KelvinBits-1:0] kelvin, input bit settle_first);
    kelvin_req_t req;
    req.kelvin       = kelvin;
    req.settle_first = settle_first;
    kelvin_queue.push_back(req);
  endtask

  // Driver: present requests from the pending queue, with random gaps
  always @(posedge clk_i) begin
    kelvin_req_t req;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && busy !== 1'b0) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (kelvin_queue.size() == 0) begin
      start <= 1'b0;
    end else if (kelvin_queue[0].settle_first && (start || rgb_in_flight != 0)) begin
      start <= 1'b0;
    end else if (kelvin_queue.size() > TailItems && $urandom_range(0, 7) == 0) begin
      gap_left <= $urandom_range(0, 17);
      start    <= 1'b0;
    end else begin
      req                  = kelvin_queue.pop_front();
      start                <= 1'b1;
      temperature_kelvin_i <= req.kelvin;
    end
  end

  // Monitor: check each result against the oldest prediction, then log new requests
  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        got.red   = red_code_o;
        got.green = green_code_o;
        got.blue  = blue_code_o;
        if (rgb_queue.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                     got.red, got.green, got.blue);
        end else begin
          want = rgb_queue.pop_front();
          results_checked++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          begin
            failures++;
            if (failures <= 10)
              $display("%0t: %0d K expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.kelvin, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
      end
      if (start && busy === 1'b0) begin
        rgb_queue.push_back(blackbody_rgb(temperature_kelvin_i));
        requests_taken++;
        if (temperature_kelvin_i > KelvinSplit) hot_requests++;
        if (temperature_kelvin_i <= KelvinBlueOff) cool_requests++;
      end
      rgb_in_flight <= rgb_queue.size();
    end
  end

  // Stimulus and end of run
  initial begin
    int sel;
    logic [KelvinBits-1:0] k;
    foreach (CornerKelvin[i]) add_kelvin(CornerKelvin[i], 1'b0);
    for (int i = 0; i < RandomItems; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8) k = KelvinBits'($urandom_range(0, 65535));
      else if (sel < 14) k = KelvinBits'($urandom_range(1, 6600));
      else if (sel < 17) begin
        case ($urandom_range(0, 4))
          0: k = KelvinBits'($urandom_range(0, 6));
          1: k = KelvinBits'($urandom_range(95, 105));
          2: k = KelvinBits'($urandom_range(1896, 1904));
          3: k = KelvinBits'($urandom_range(5996, 6004));
          default: k = KelvinBits'($urandom_range(6596, 6604));
        endcase
      end else k = KelvinBits'($urandom_range(6601, 20000));
      // let the pipeline empty at the start of the random part and midway
      add_kelvin(k, i == 0 || i == RandomItems / 2);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    do @(negedge clk_i);
    while (kelvin_queue.size() != 0 || start || rgb_in_flight != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d temperatures (%0d at or below 1900 K, %0d above 6600 K),",
             requests_taken, cool_requests, hot_requests);
    $display("checked %0d RGB results, %0d failures.", results_checked, failures);
    if (failures == 0) begin
      $display("** color_temperature_to_rgb_top: PASSED **");
    end else begin
      $display("** color_temperature_to_rgb_top: FAILED **");
    end
    $finish;
  end

  // Abort a run that stops making progress
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", rgb_in_flight);
    $display("** color_temperature_to_rgb_top: FAILED **");
    $finish;
  end

endmodule
